[rtl/ttge_pkg.sv]
// shared types, codes and constants of the text terminal grid engine
package ttge_pkg;

   // default grid geometry
   localparam int MAX_ROWS_DEF = 32;
   localparam int MAX_COLS_DEF = 128;

   // tab stops every eight columns
   localparam int TAB_WIDTH = 8;

   // width of the cursor and argument arithmetic
   localparam int SW = 10;

   // operation codes
   localparam logic [3:0] OP_PUT        = 4'd0;
   localparam logic [3:0] OP_CR         = 4'd1;
   localparam logic [3:0] OP_LF         = 4'd2;
   localparam logic [3:0] OP_BS         = 4'd3;
   localparam logic [3:0] OP_TAB        = 4'd4;
   localparam logic [3:0] OP_UP         = 4'd5;
   localparam logic [3:0] OP_DOWN       = 4'd6;
   localparam logic [3:0] OP_FWD        = 4'd7;
   localparam logic [3:0] OP_BACK       = 4'd8;
   localparam logic [3:0] OP_POSITION   = 4'd9;
   localparam logic [3:0] OP_ERASE_LINE = 4'd10;
   localparam logic [3:0] OP_ERASE_DISP = 4'd11;
   localparam logic [3:0] OP_READ_CELL  = 4'd12;

   // erase modes
   localparam logic [1:0] ERASE_TO_END     = 2'd0;
   localparam logic [1:0] ERASE_FROM_START = 2'd1;
   localparam logic [1:0] ERASE_ALL        = 2'd2;

   // configuration register indexes
   localparam logic [0:0] CSR_COLUMNS = 1'b0;
   localparam logic [0:0] CSR_ROWS    = 1'b1;

   // register reset values
   localparam logic [7:0] COLS_RESET = 8'd80;
   localparam logic [5:0] ROWS_RESET = 6'd24;

   // character codes
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UNKNOWN = 8'h3F;
   localparam logic [7:0] CHAR_DEL     = 8'h7F;

   typedef struct packed {
      logic [3:0] opcode;
      logic [7:0] data_byte;
      logic [7:0] move_count;
      logic [7:0] row_arg;
      logic [7:0] col_arg;
      logic [1:0] erase_mode;
   } req_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [31:0] dirty_rows;
      logic [7:0]  cell_value;
   } rsp_type;

   // dirty bit of one row, rows beyond 31 have none
   function automatic logic [31:0] row_bit(input logic [SW-1:0] r);
      logic [31:0] b;
      for (int i = 0; i < 32; i++) begin
         b[i] = (r == SW'(i));
      end
      return b;
   endfunction

   // dirty bits of all rows below a row count
   function automatic logic [31:0] row_mask(input logic [SW-1:0] rows);
      logic [31:0] b;
      for (int i = 0; i < 32; i++) begin
         b[i] = (SW'(i) < rows);
      end
      return b;
   endfunction

endpackage

[rtl/ttge_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
module ttge_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/text_terminal_grid_engine_core.sv]
// Text terminal character grid: cursor, cell memory, scroll and erase sweeps.
//
// Commands enter on req_data, taken at a clock edge where start is high and
// busy is low. Every command gives one transaction on rsp_data, marked by
// rsp_strobe for a single cycle; the receiver always takes it.
// Configuration: csr_we writes csr_wdata to register csr_index at once
// (0 columns in use, 1 rows in use); write only while the block is idle.
// Flow, from the accepting edge: each command is registered and decoded in
// S_EXEC, which itself answers every command that the list below does not name;
// busy stays high until a command's result, so a new command is not taken before it.
//   read cell (in range): through S_READ for the registered cell memory read
//   erase line: through S_WIPE, which clears the chosen cells of the row
//   erase display (erase all): S_WIPE over all MAX_ROWS * MAX_COLS cells
//   scroll (put or line feed past the bottom row): S_SCROLL copies
//   (active rows - 1) * MAX_COLS cells a row up, S_WIPE clears the new row
// The cell memory has one write and one read port; the copy and clear
// sweeps move one cell per cycle through it.
// Reset starts a clearing pass that writes a space to all MAX_ROWS * MAX_COLS
// cells, one per cycle; busy stays high during it and configuration writes
// are still taken. No result is produced by reset.
module text_terminal_grid_engine_core #(
   parameter int MAX_ROWS = ttge_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS = ttge_pkg::MAX_COLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ttge_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ttge_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [7:0]        csr_wdata
);

   import ttge_pkg::*;

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW    = $clog2(MAX_COLS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCROLL = 3'd3;
   localparam logic [2:0] S_WIPE   = 3'd4;

   // cell address of a row and column
   function automatic logic [AW:0] cell_addr(input logic [SW-1:0] r, input logic [SW-1:0] c);
      return (AW+1)'(r) * (AW+1)'(MAX_COLS) + (AW+1)'(c);
   endfunction

   logic [2:0]    state_ff, state_in;
   logic [RW-1:0] cursor_row_ff, cursor_row_in;
   logic [CW-1:0] cursor_col_ff, cursor_col_in;
   logic [31:0]   dirty_ff, dirty_in;
   logic [7:0]    cfg_cols_ff, cfg_cols_in;
   logic [5:0]    cfg_rows_ff, cfg_rows_in;
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic [AW:0]   wipe_addr_ff, wipe_addr_in;
   logic [AW:0]   wipe_end_ff, wipe_end_in;
   logic          wipe_resp_ff, wipe_resp_in;
   logic          take_ff, take_in;
   logic [AW:0]   copy_addr_ff, copy_addr_in;
   logic          copy_wr_ff, copy_wr_in;
   logic [AW-1:0] copy_dst_ff, copy_dst_in;

   // cell memory ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic          ram_re;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   // active geometry and clamped cursor
   logic [SW-1:0] rows_w, cols_w, rows_m1, cols_m1;
   logic [SW-1:0] cur_row_w, cur_col_w, r0, c0;
   logic [SW-1:0] n_w, ra_w, ca_w, t_w;
   logic [AW:0]   scroll_end, last_base, ex_base;

   // decoded command
   logic [SW-1:0] ex_row, ex_col;
   logic [31:0]   ex_mark, dirty_next;
   logic          ex_take, ex_scroll, ex_wipe, ex_write, ex_read;
   logic [AW:0]   ex_wipe_lo, ex_wipe_hi, ex_waddr, ex_raddr;
   logic [7:0]    ex_wdata;

   ttge_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // active area, register values out of range are pulled inside
   always_comb begin
      if (cfg_rows_ff == '0) begin
         rows_w = SW'(1);
      end else if (SW'(cfg_rows_ff) > SW'(MAX_ROWS)) begin
         rows_w = SW'(MAX_ROWS);
      end else begin
         rows_w = SW'(cfg_rows_ff);
      end
      if (cfg_cols_ff == '0) begin
         cols_w = SW'(1);
      end else if (SW'(cfg_cols_ff) > SW'(MAX_COLS)) begin
         cols_w = SW'(MAX_COLS);
      end else begin
         cols_w = SW'(cfg_cols_ff);
      end
      rows_m1    = rows_w - SW'(1);
      cols_m1    = cols_w - SW'(1);
      cur_row_w  = SW'(cursor_row_ff);
      cur_col_w  = SW'(cursor_col_ff);
      r0         = (cur_row_w > rows_m1) ? rows_m1 : cur_row_w;
      c0         = (cur_col_w > cols_m1) ? cols_m1 : cur_col_w;
      scroll_end = cell_addr(rows_w, '0);
      last_base  = cell_addr(rows_m1, '0);
      ex_base    = cell_addr(r0, '0);
   end

   // command decode on the clamped cursor
   always_comb begin
      n_w        = SW'(req_ff.move_count);
      ra_w       = SW'(req_ff.row_arg);
      ca_w       = SW'(req_ff.col_arg);
      t_w        = '0;
      ex_row     = r0;
      ex_col     = c0;
      ex_mark    = '0;
      ex_take    = 1'b0;
      ex_scroll  = 1'b0;
      ex_wipe    = 1'b0;
      ex_write   = 1'b0;
      ex_read    = 1'b0;
      ex_wipe_lo = ex_base;
      ex_wipe_hi = ex_base;
      ex_waddr   = cell_addr(r0, c0);
      ex_raddr   = cell_addr(ra_w, ca_w);
      ex_wdata   = req_ff.data_byte;
      unique case (req_ff.opcode)
         OP_PUT: begin
            if (req_ff.data_byte < CHAR_SPACE || req_ff.data_byte >= CHAR_DEL) begin
               ex_wdata = CHAR_UNKNOWN;
            end
            ex_write = 1'b1;
            ex_take  = 1'b1;
            ex_mark  = row_bit(r0);
            if (c0 + SW'(1) >= cols_w) begin
               ex_col = '0;
               if (r0 + SW'(1) >= rows_w) begin
                  ex_scroll = 1'b1;
                  ex_row    = rows_m1;
                  ex_mark   = row_bit(r0) | row_mask(rows_w);
               end else begin
                  ex_row = r0 + SW'(1);
               end
            end else begin
               ex_col = c0 + SW'(1);
            end
         end
         OP_CR: begin
            ex_col = '0;
         end
         OP_LF: begin
            ex_col = '0;
            if (r0 + SW'(1) >= rows_w) begin
               ex_scroll = 1'b1;
               ex_row    = rows_m1;
               ex_mark   = row_mask(rows_w);
            end else begin
               ex_row = r0 + SW'(1);
            end
         end
         OP_BS: begin
            ex_col = (c0 != '0) ? c0 - SW'(1) : '0;
         end
         OP_TAB: begin
            t_w    = (c0 + SW'(TAB_WIDTH)) & ~SW'(TAB_WIDTH - 1);
            ex_col = (t_w < cols_m1) ? t_w : cols_m1;
         end
         OP_UP: begin
            ex_row = (n_w >= r0) ? '0 : r0 - n_w;
         end
         OP_DOWN: begin
            t_w    = r0 + n_w;
            ex_row = (t_w < rows_m1) ? t_w : rows_m1;
         end
         OP_FWD: begin
            t_w    = c0 + n_w;
            ex_col = (t_w < cols_m1) ? t_w : cols_m1;
         end
         OP_BACK: begin
            ex_col = (n_w >= c0) ? '0 : c0 - n_w;
         end
         OP_POSITION: begin
            t_w    = (ra_w == '0) ? '0 : ra_w - SW'(1);
            ex_row = (t_w < rows_m1) ? t_w : rows_m1;
            t_w    = (ca_w == '0) ? '0 : ca_w - SW'(1);
            ex_col = (t_w < cols_m1) ? t_w : cols_m1;
         end
         OP_ERASE_LINE: begin
            ex_wipe = 1'b1;
            ex_take = 1'b1;
            ex_mark = row_bit(r0);
            unique case (req_ff.erase_mode)
               ERASE_TO_END: begin
                  ex_wipe_lo = cell_addr(r0, c0);
                  ex_wipe_hi = cell_addr(r0, cols_w);
               end
               ERASE_FROM_START: begin
                  ex_wipe_lo = ex_base;
                  ex_wipe_hi = cell_addr(r0, c0 + SW'(1));
               end
               default: begin
                  ex_wipe_lo = ex_base;
                  ex_wipe_hi = cell_addr(r0, cols_w);
               end
            endcase
         end
         OP_ERASE_DISP: begin
            if (req_ff.erase_mode == ERASE_ALL) begin
               ex_wipe    = 1'b1;
               ex_take    = 1'b1;
               ex_mark    = row_mask(rows_w);
               ex_wipe_lo = '0;
               ex_wipe_hi = (AW+1)'(DEPTH);
            end
         end
         OP_READ_CELL: begin
            ex_read = (ra_w < rows_w) && (ca_w < cols_w);
         end
         default: begin
         end
      endcase
   end

   assign dirty_next = dirty_ff | ex_mark;

   // sequencer and memory port control
   always_comb begin
      state_in      = state_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      dirty_in      = dirty_ff;
      cfg_cols_in   = cfg_cols_ff;
      cfg_rows_in   = cfg_rows_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      wipe_addr_in  = wipe_addr_ff;
      wipe_end_in   = wipe_end_ff;
      wipe_resp_in  = wipe_resp_ff;
      take_in       = take_ff;
      copy_addr_in  = copy_addr_ff;
      copy_wr_in    = 1'b0;
      copy_dst_in   = copy_dst_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = CHAR_SPACE;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS: cfg_cols_in = csr_wdata;
            CSR_ROWS:    cfg_rows_in = csr_wdata[5:0];
            default:     cfg_cols_in = cfg_cols_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cursor_row_in = RW'(ex_row);
            cursor_col_in = CW'(ex_col);
            ram_we        = ex_write;
            ram_waddr     = ex_waddr[AW-1:0];
            ram_wdata     = ex_wdata;
            ram_re        = ex_read;
            ram_raddr     = ex_raddr[AW-1:0];
            take_in       = ex_take;
            wipe_resp_in  = 1'b1;
            priority if (ex_scroll) begin
               dirty_in     = dirty_next;
               copy_addr_in = (AW+1)'(MAX_COLS);
               state_in     = S_SCROLL;
            end else if (ex_wipe) begin
               dirty_in     = dirty_next;
               wipe_addr_in = ex_wipe_lo;
               wipe_end_in  = ex_wipe_hi;
               state_in     = S_WIPE;
            end else if (ex_read) begin
               state_in = S_READ;
            end else begin
               state_in          = S_IDLE;
               rsp_strobe_in     = 1'b1;
               rsp_in.cursor_row = ex_row[4:0];
               rsp_in.cursor_col = ex_col[6:0];
               rsp_in.cell_value = '0;
               rsp_in.dirty_rows = ex_take ? dirty_next : '0;
               dirty_in          = ex_take ? '0 : dirty_next;
            end
         end
         S_READ: begin
            state_in          = S_IDLE;
            rsp_strobe_in     = 1'b1;
            rsp_in.cursor_row = cur_row_w[4:0];
            rsp_in.cursor_col = cur_col_w[6:0];
            rsp_in.dirty_rows = '0;
            rsp_in.cell_value = ram_rdata;
         end
         S_SCROLL: begin
            // copy one cell a row up, each write follows its read in the next cycle
            if (copy_wr_ff) begin
               ram_we    = 1'b1;
               ram_waddr = copy_dst_ff;
               ram_wdata = ram_rdata;
            end
            if (copy_addr_ff < scroll_end) begin
               ram_re       = 1'b1;
               ram_raddr    = copy_addr_ff[AW-1:0];
               copy_wr_in   = 1'b1;
               copy_dst_in  = AW'(copy_addr_ff - (AW+1)'(MAX_COLS));
               copy_addr_in = copy_addr_ff + (AW+1)'(1);
            end else begin
               wipe_addr_in = last_base;
               wipe_end_in  = scroll_end;
               state_in     = S_WIPE;
            end
         end
         S_WIPE: begin
            // fill a cell range with spaces, then report unless the pass came from reset
            if (wipe_addr_ff < wipe_end_ff) begin
               ram_we       = 1'b1;
               ram_waddr    = wipe_addr_ff[AW-1:0];
               ram_wdata    = CHAR_SPACE;
               wipe_addr_in = wipe_addr_ff + (AW+1)'(1);
            end else begin
               state_in = S_IDLE;
               if (wipe_resp_ff) begin
                  rsp_strobe_in     = 1'b1;
                  rsp_in.cursor_row = cur_row_w[4:0];
                  rsp_in.cursor_col = cur_col_w[6:0];
                  rsp_in.cell_value = '0;
                  rsp_in.dirty_rows = take_ff ? dirty_ff : '0;
                  if (take_ff) begin
                     dirty_in = '0;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_WIPE;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         dirty_ff      <= '0;
         cfg_cols_ff   <= COLS_RESET;
         cfg_rows_ff   <= ROWS_RESET;
         rsp_strobe_ff <= 1'b0;
         wipe_addr_ff  <= '0;
         wipe_end_ff   <= (AW+1)'(DEPTH);
         wipe_resp_ff  <= 1'b0;
         take_ff       <= 1'b0;
         copy_wr_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         dirty_ff      <= dirty_in;
         cfg_cols_ff   <= cfg_cols_in;
         cfg_rows_ff   <= cfg_rows_in;
         rsp_strobe_ff <= rsp_strobe_in;
         wipe_addr_ff  <= wipe_addr_in;
         wipe_end_ff   <= wipe_end_in;
         wipe_resp_ff  <= wipe_resp_in;
         take_ff       <= take_in;
         copy_wr_ff    <= copy_wr_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      copy_addr_ff <= copy_addr_in;
      copy_dst_ff  <= copy_dst_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // a command is taken in S_IDLE and answered no earlier than S_EXEC, so strobes never touch
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on two consecutive cycles");

   // an accepted command keeps the block busy and gives no result at once
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted transaction did not occupy the block");

   // reset starts the clearing pass without a result
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (busy && !rsp_strobe && state_ff == S_WIPE))
      else $error("reset did not start the clearing pass");

   // the copy write always lands at a lower address than the cell being read
   a_scroll_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL && copy_wr_ff) |-> ((AW+1)'(copy_dst_ff) < copy_addr_ff))
      else $error("scroll copy overtook its read pointer");

endmodule

[test/ttge_grid_checker.sv]
// grid checker: predicts each command's response and compares it with the core's
`timescale 1ns / 1ps

module ttge_grid_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  ttge_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  ttge_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [0:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output int                mismatch_count,
   output int                pending_count
);

   import ttge_pkg::*;

   localparam int GRID_ROWS = MAX_ROWS_DEF;
   localparam int GRID_COLS = MAX_COLS_DEF;
   localparam int PRINT_CAP = 30;

   // shadow of the terminal
   logic [7:0]  screen [0:GRID_ROWS*GRID_COLS-1];
   int          cur_row;
   int          cur_col;
   logic [31:0] dirty_acc;
   logic [7:0]  cols_reg;
   logic [5:0]  rows_reg;

   rsp_type     responses_due[$];
   int          errors;
   int          rsp_seen;

   // one line per mismatch, printing capped
   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= PRINT_CAP) begin
         $display("[%0t] mismatch on transaction %0d: %s", $time, rsp_seen, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      end
   endtask

   task automatic blank_cells(input int r, input int from, input int upto);
      for (int c = from; c < upto && c < GRID_COLS; c++) begin
         screen[r*GRID_COLS+c] = CHAR_SPACE;
      end
   endtask

   task automatic mark_row(input int r);
      if (r < 32) dirty_acc[r] = 1'b1;
   endtask

   // shift active rows up by one, blank the bottom one
   task automatic scroll_screen(input int rows);
      for (int r = 0; r < rows; r++) begin
         if (r + 1 < rows) begin
            for (int c = 0; c < GRID_COLS; c++) begin
               screen[r*GRID_COLS+c] = screen[(r+1)*GRID_COLS+c];
            end
         end
         mark_row(r);
      end
      blank_cells(rows - 1, 0, GRID_COLS);
      cur_row = rows - 1;
      cur_col = 0;
   endtask

   task automatic reset_terminal();
      for (int i = 0; i < GRID_ROWS*GRID_COLS; i++) screen[i] = CHAR_SPACE;
      cur_row   = 0;
      cur_col   = 0;
      dirty_acc = '0;
      cols_reg  = COLS_RESET;
      rows_reg  = ROWS_RESET;
   endtask

   // terminal behavior for one command
   task automatic run_terminal_command(input req_type cmd, output rsp_type res);
      int          rows;
      int          cols;
      int          t;
      int          n;
      int          ra;
      int          ca;
      logic [7:0]  ch;
      logic [31:0] flushed;
      logic [7:0]  cell_byte;
      rows      = (rows_reg == 0) ? 1 : (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
      cols      = (cols_reg == 0) ? 1 : (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
      n         = int'(cmd.move_count);
      ra        = int'(cmd.row_arg);
      ca        = int'(cmd.col_arg);
      flushed   = '0;
      cell_byte = '0;
      // cursor may sit outside a shrunken area
      if (cur_row >= rows) cur_row = rows - 1;
      if (cur_col >= cols) cur_col = cols - 1;
      case (cmd.opcode)
         OP_PUT: begin
            ch = cmd.data_byte;
            if (ch < CHAR_SPACE || ch >= CHAR_DEL) ch = CHAR_UNKNOWN;
            screen[cur_row*GRID_COLS+cur_col] = ch;
            mark_row(cur_row);
            cur_col++;
            if (cur_col >= cols) begin
               cur_col = 0;
               cur_row++;
               if (cur_row >= rows) scroll_screen(rows);
            end
            flushed   = dirty_acc;
            dirty_acc = '0;
         end
         OP_CR: cur_col = 0;
         OP_LF: begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rows) scroll_screen(rows);
         end
         OP_BS: if (cur_col > 0) cur_col--;
         OP_TAB: begin
            t = (cur_col + TAB_WIDTH) & ~(TAB_WIDTH - 1);
            cur_col = (t < cols - 1) ? t : cols - 1;
         end
         OP_UP: cur_row = (n >= cur_row) ? 0 : cur_row - n;
         OP_DOWN: begin
            t = cur_row + n;
            cur_row = (t < rows - 1) ? t : rows - 1;
         end
         OP_FWD: begin
            t = cur_col + n;
            cur_col = (t < cols - 1) ? t : cols - 1;
         end
         OP_BACK: cur_col = (n >= cur_col) ? 0 : cur_col - n;
         OP_POSITION: begin
            t = (ra == 0) ? 0 : ra - 1;
            cur_row = (t < rows - 1) ? t : rows - 1;
            t = (ca == 0) ? 0 : ca - 1;
            cur_col = (t < cols - 1) ? t : cols - 1;
         end
         OP_ERASE_LINE: begin
            if (cmd.erase_mode == ERASE_TO_END) blank_cells(cur_row, cur_col, cols);
            else if (cmd.erase_mode == ERASE_FROM_START) blank_cells(cur_row, 0, cur_col + 1);
            else blank_cells(cur_row, 0, cols);
            mark_row(cur_row);
            flushed   = dirty_acc;
            dirty_acc = '0;
         end
         OP_ERASE_DISP: begin
            if (cmd.erase_mode == ERASE_ALL) begin
               for (int i = 0; i < GRID_ROWS*GRID_COLS; i++) screen[i] = CHAR_SPACE;
               for (int r = 0; r < rows; r++) mark_row(r);
               flushed   = dirty_acc;
               dirty_acc = '0;
            end
         end
         OP_READ_CELL: begin
            if (ra < rows && ca < cols) cell_byte = screen[ra*GRID_COLS+ca];
         end
         default: ;
      endcase
      res.cursor_row = 5'(cur_row);
      res.cursor_col = 7'(cur_col);
      res.dirty_rows = flushed;
      res.cell_value = cell_byte;
   endtask

   // watch both channels and the register port at each rising edge
   always @(posedge clock) begin
      rsp_type want;
      rsp_type made;
      if (reset) begin
         reset_terminal();
         responses_due.delete();
         errors   = 0;
         rsp_seen = 0;
      end else begin
         // compare before taking a new command
         if (rsp_strobe) begin
            if (responses_due.size() == 0) begin
               report_mismatch("response with no command outstanding");
            end else begin
               want = responses_due.pop_front();
               check_field("cursor_row", 32'(rsp_data.cursor_row), 32'(want.cursor_row));
               check_field("cursor_col", 32'(rsp_data.cursor_col), 32'(want.cursor_col));
               check_field("dirty_rows", rsp_data.dirty_rows, want.dirty_rows);
               check_field("cell_value", 32'(rsp_data.cell_value), 32'(want.cell_value));
            end
            rsp_seen++;
         end
         // register writes
         if (csr_we) begin
            if (csr_index == CSR_COLUMNS) cols_reg = csr_wdata;
            else rows_reg = csr_wdata[5:0];
         end
         // accepted command
         if (start && !busy) begin
            run_terminal_command(req_data, made);
            responses_due.push_back(made);
         end
      end
      mismatch_count <= errors;
      pending_count  <= responses_due.size();
   end

endmodule

[test/testbench.sv]
// top of the grid engine test: clock, reset, command stimulus and verdict
`timescale 1ns / 1ps

module testbench;
   import ttge_pkg::*;

   localparam int CYCLE_LIMIT = 12_000_000;
   localparam int DRAIN_CYCLES = 4500;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [0:0] csr_index;
   logic [7:0] csr_wdata;
   int         mismatch_count;
   int         pending_count;
   int         cycle_count;
   logic [4:0] seen_row;
   logic [6:0] seen_col;

   text_terminal_grid_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ttge_grid_checker grid_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // last reported cursor, used to aim cell reads at written text
   initial begin
      seen_row = '0;
      seen_col = '0;
   end
   always @(posedge clock) begin
      if (rsp_strobe) begin
         seen_row <= rsp_data.cursor_row;
         seen_col <= rsp_data.cursor_col;
      end
   end

   function automatic req_type make_cmd(input logic [3:0] op, input logic [7:0] data,
                                        input logic [7:0] count, input logic [7:0] row,
                                        input logic [7:0] col, input logic [1:0] mode);
      req_type c;
      c.opcode     = op;
      c.data_byte  = data;
      c.move_count = count;
      c.row_arg    = row;
      c.col_arg    = col;
      c.erase_mode = mode;
      return c;
   endfunction

   // random command, text most often, with cursor control, erase and reads mixed in
   function automatic req_type random_command(input int cols, input int rows);
      req_type c;
      int      pick;
      c.data_byte  = 8'($urandom);
      c.move_count = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20));
      c.row_arg    = 8'($urandom);
      c.col_arg    = 8'($urandom);
      c.erase_mode = 2'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         c.opcode = OP_PUT;
         if ($urandom_range(0, 9) < 7) c.data_byte = 8'($urandom_range(32, 126));
      end else if (pick < 50) c.opcode = OP_CR;
      else if (pick < 56) c.opcode = OP_LF;
      else if (pick < 60) c.opcode = OP_BS;
      else if (pick < 64) c.opcode = OP_TAB;
      else if (pick < 68) c.opcode = OP_UP;
      else if (pick < 72) c.opcode = OP_DOWN;
      else if (pick < 76) c.opcode = OP_FWD;
      else if (pick < 80) c.opcode = OP_BACK;
      else if (pick < 84) begin
         c.opcode = OP_POSITION;
         if ($urandom_range(0, 4) != 0) begin
            c.row_arg = 8'($urandom_range(0, rows + 1));
            c.col_arg = 8'($urandom_range(0, cols + 1));
         end
      end else if (pick < 89) c.opcode = OP_ERASE_LINE;
      else if (pick < 92) c.opcode = OP_ERASE_DISP;
      else if (pick < 98) begin
         c.opcode = OP_READ_CELL;
         case ($urandom_range(0, 4))
            0, 1: begin
               c.row_arg = 8'(seen_row);
               c.col_arg = 8'($urandom_range(0, int'(seen_col)));
            end
            2, 3: begin
               c.row_arg = 8'($urandom_range(0, rows));
               c.col_arg = 8'($urandom_range(0, cols));
            end
            default: ;
         endcase
      end else c.opcode = 4'($urandom_range(int'(OP_READ_CELL) + 1, 15));
      return c;
   endfunction

   // present one command and hold it until taken
   task automatic send_command(input req_type c);
      start    = 1'b1;
      req_data = c;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic pause_sender(input int n);
      repeat (n) @(negedge clock);
   endtask

   // wait until every response is in and the core is idle
   task automatic settle();
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [0:0] idx, input logic [7:0] value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one register setting followed by random commands
   task automatic run_phase(input logic [7:0] cols_w, input logic [7:0] rows_w,
                            input int count, input int idle_pct);
      int cols;
      int rows;
      cols = (cols_w == 0) ? 1 : (cols_w > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_w);
      rows = (rows_w[5:0] == 0) ? 1 :
             (rows_w[5:0] > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_w[5:0]);
      settle();
      write_register(CSR_COLUMNS, cols_w);
      write_register(CSR_ROWS, rows_w);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < idle_pct) pause_sender($urandom_range(1, 15));
         if (idle_pct != 0 && $urandom_range(0, 99) == 0) settle();
         send_command(random_command(cols, rows));
      end
      // leave the cursor at the far corner so a smaller grid must clamp it
      send_command(make_cmd(OP_POSITION, 8'h00, 8'h00, 8'hFF, 8'hFF, ERASE_TO_END));
   endtask

   // stimulus and verdict
   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_COLUMNS;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      settle();

      // directed commands on the reset geometry, 80 by 24
      send_command(make_cmd(OP_PUT, 8'h41, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_PUT, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_PUT, 8'h1F, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_PUT, 8'h20, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_PUT, 8'h7E, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_PUT, 8'h7F, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_PUT, 8'hFF, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 8'h00, 8'h01, ERASE_TO_END));
      send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 8'h00, 8'h04, ERASE_TO_END));
      send_command(make_cmd(OP_BS, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_CR, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_BS, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_TAB, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_FWD, 8'h00, 8'hFF, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_TAB, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_BACK, 8'h00, 8'hFF, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_DOWN, 8'h00, 8'hFF, 8'h00, 8'h00, ERASE_TO_END));
      // line feed on the bottom row scrolls
      send_command(make_cmd(OP_LF, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      settle();
      send_command(make_cmd(OP_READ_CELL, 8'h00, 8'h00, 8'h18, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_UP, 8'h00, 8'hFF, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_POSITION, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_POSITION, 8'h00, 8'h00, 8'hFF, 8'hFF, ERASE_TO_END));
      // put on the last cell wraps and scrolls
      send_command(make_cmd(OP_PUT, 8'h5A, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_POSITION, 8'h00, 8'h00, 8'h17, 8'h05, ERASE_TO_END));
      send_command(make_cmd(OP_ERASE_LINE, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));
      send_command(make_cmd(OP_ERASE_LINE, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_FROM_START));
      send_command(make_cmd(OP_ERASE_LINE, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_ALL));
      send_command(make_cmd(OP_ERASE_DISP, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_FROM_START));
      send_command(make_cmd(OP_ERASE_DISP, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_ALL));
      send_command(make_cmd(4'hF, 8'h00, 8'h00, 8'h00, 8'h00, ERASE_TO_END));

      // register settings, extremes and out-of-range values among them
      run_phase(8'd128, 8'd32, 100, 30);
      run_phase(8'd1, 8'd1, 50, 0);
      run_phase(8'd0, 8'd0, 30, 50);
      run_phase(8'hFF, 8'hFF, 70, 20);
      run_phase(8'd8, 8'd4, 90, 0);
      run_phase(8'($urandom_range(1, 128)), 8'($urandom_range(1, 32)), 80, 40);
      run_phase(8'd17, 8'd3, 80, 25);
      run_phase(COLS_RESET, 8'(ROWS_RESET), 120, 0);

      // drain and verdict
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
